FILE: rtl/assert_macros.svh
// Assertion helpers for the bound checker in adpm_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while out of reset.
`define ADPM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked on every edge, reset included.
`define ADPM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

FILE: rtl/adpm_pkg.sv
`timescale 1ns / 1ps
package adpm_pkg;

	localparam int CFG_W   = 17;
	localparam int IDX_W   = 2;
	localparam int LEVEL_W = 16;
	localparam int MANT_W  = 8;
	localparam int DB_PER_OCT_Q8 = 771;

	localparam logic [CFG_W-1:0]          ATTACK_RESET = 17'd6554;
	localparam logic [CFG_W-1:0]          DECAY_RESET  = 17'd655;
	localparam logic signed [LEVEL_W-1:0] FLOOR_RESET  = -16'sd30720;

	typedef enum logic [IDX_W-1:0] {
		REG_ATTACK = 2'd0,
		REG_DECAY  = 2'd1,
		REG_FLOOR  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0]          attack_alpha;
		logic [CFG_W-1:0]          decay_alpha;
		logic signed [LEVEL_W-1:0] floor_db;
	} cfg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_ADD,
		BK_NORM,
		BK_LUT,
		BK_SCALE,
		BK_OUT
	} bk_state_t;

	// round(256*log2(1+i/256)) by repeated squaring, 9 fraction bits, rounded half up
	typedef logic [8:0] log_tab_t [256];

	function automatic log_tab_t build_log_tab();
		log_tab_t    t;
		logic [63:0] y;
		logic [9:0]  frac;
		for (int i = 0; i < 256; i++) begin
			y = 64'(256 + i) << 22;
			frac = '0;
			for (int k = 0; k < 9; k++) begin
				y = (y * y) >> 30;
				frac = frac << 1;
				if (y >= 64'h8000_0000) begin
					frac[0] = 1'b1;
					y = y >> 1;
				end
			end
			t[i] = 9'((frac + 10'd1) >> 1);
		end
		return t;
	endfunction

	localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

FILE: rtl/adpm_front.sv
`timescale 1ns / 1ps
module adpm_front #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          report,
	output logic                          push,
	output logic [2*SAMPLE_BITS-1:0]      push_data,
	input  logic                          full
);

	localparam int PW = 2*SAMPLE_BITS - 1;

	logic                       v_s1;
	logic [PW-1:0]              p_s1;
	logic                       rpt_s1;
	logic signed [2*SAMPLE_BITS-1:0] sq;
	logic                       take;

	assign sq        = sample * sample;
	assign in_stall  = v_s1 && full;
	assign take      = in_valid && !in_stall;
	assign push      = v_s1 && !full;
	assign push_data = {rpt_s1, p_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			p_s1   <= sq[PW-1:0];
			rpt_s1 <= report;
		end
	end

endmodule

FILE: rtl/adpm_fifo.sv
`timescale 1ns / 1ps
module adpm_fifo #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	localparam int DEPTH = 2;

	logic [WIDTH-1:0]           mem_q [DEPTH];
	logic                       wr_ptr_q;
	logic                       rd_ptr_q;
	logic [$clog2(DEPTH+1)-1:0] cnt_q;

	assign full       = (cnt_q == 2'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/adpm_back.sv
`timescale 1ns / 1ps
module adpm_back #(
	parameter int SAMPLE_BITS     = 16,
	parameter int ALPHA_FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  adpm_pkg::cfg_t                        cfg,
	input  logic                                  head_valid,
	input  logic [2*SAMPLE_BITS-1:0]              head_data,
	output logic                                  pop,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [adpm_pkg::LEVEL_W-1:0]   level_db
);

	localparam int AW   = 2*SAMPLE_BITS - 1;
	localparam int DW   = AW + 1;
	localparam int AFW  = ALPHA_FRAC_BITS + 1;
	localparam int XW   = adpm_pkg::CFG_W + ALPHA_FRAC_BITS;
	localparam int PRW  = DW + AFW + 1;
	localparam int SHW  = $clog2(AW);
	localparam int NW   = 1 << SHW;
	localparam int STW  = $clog2(SHW);
	localparam int LW   = SHW + 10;
	localparam int SCW  = LW + 11;
	localparam int MANT_SEL_W = adpm_pkg::MANT_W;
	localparam logic [XW-1:0] A_ONE = XW'(1) << ALPHA_FRAC_BITS;
	localparam logic signed [SCW-1:0] DB_MIN = SCW'(-32768);
	localparam logic signed [SCW-1:0] DB_MAX = SCW'(32767);
	localparam logic signed [10:0]    DB_K   = 11'(adpm_pkg::DB_PER_OCT_Q8);

	adpm_pkg::bk_state_t st_q, st_d;

	logic [AW-1:0]            avg_q;
	logic                     rpt_q;
	logic signed [DW-1:0]     d_q;
	logic [AFW-1:0]           a_q;
	logic signed [PRW-1:0]    prod_q;
	logic [NW-1:0]            norm_q;
	logic [SHW-1:0]           sh_q;
	logic [STW-1:0]           stp_q;
	logic                     zero_q;
	logic signed [LW-1:0]     lg_q;
	logic signed [SCW-1:0]    scl_q;
	logic                     out_v_q;
	logic signed [adpm_pkg::LEVEL_W-1:0] level_q;

	logic [AW-1:0]            head_p;
	logic                     rise;
	logic [adpm_pkg::CFG_W-1:0] alpha_sel;
	logic [AFW-1:0]           a_d;
	logic signed [PRW-1:0]    delta_w;
	logic signed [PRW-1:0]    sum_w;
	logic [AW-1:0]            avg_new;
	logic [SHW-1:0]           amt;
	logic [NW-1:0]            top_mask;
	logic [MANT_SEL_W-1:0]    mant;
	logic signed [SCW-1:0]    db;
	logic signed [adpm_pkg::LEVEL_W-1:0] db_sat;
	logic                     out_ld;

	assign head_p    = head_data[AW-1:0];
	assign rise      = head_p > avg_q;
	assign alpha_sel = rise ? cfg.attack_alpha : cfg.decay_alpha;
	assign a_d       = (XW'(alpha_sel) > A_ONE) ? AFW'(A_ONE) : AFW'(alpha_sel);

	// floor(alpha*diff / 2^F): arithmetic shift of the signed product
	assign delta_w = prod_q >>> ALPHA_FRAC_BITS;
	assign sum_w   = $signed({{(PRW-AW){1'b0}}, avg_q}) + delta_w;
	assign avg_new = sum_w[AW-1:0];

	// binary leading-one search, halving the window each step
	assign amt      = SHW'(1) << stp_q;
	assign top_mask = ~({NW{1'b1}} >> amt);
	assign mant     = norm_q[NW-2 -: MANT_SEL_W];

	assign db     = scl_q >>> 8;
	assign db_sat = (db < DB_MIN) ? adpm_pkg::LEVEL_W'(DB_MIN) :
	                (db > DB_MAX) ? adpm_pkg::LEVEL_W'(DB_MAX) :
	                adpm_pkg::LEVEL_W'(db);

	always_comb begin
		st_d = st_q;
		case (st_q)
			adpm_pkg::BK_IDLE: begin
				if (head_valid) begin
					st_d = adpm_pkg::BK_MUL;
				end
			end
			adpm_pkg::BK_MUL:   st_d = adpm_pkg::BK_ADD;
			adpm_pkg::BK_ADD:   st_d = rpt_q ? adpm_pkg::BK_NORM : adpm_pkg::BK_IDLE;
			adpm_pkg::BK_NORM: begin
				if (stp_q == '0) begin
					st_d = adpm_pkg::BK_LUT;
				end
			end
			adpm_pkg::BK_LUT:   st_d = adpm_pkg::BK_SCALE;
			adpm_pkg::BK_SCALE: st_d = adpm_pkg::BK_OUT;
			adpm_pkg::BK_OUT: begin
				if (!out_v_q || !out_stall) begin
					st_d = adpm_pkg::BK_IDLE;
				end
			end
			default: st_d = adpm_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop    = 1'b0;
		out_ld = 1'b0;
		case (st_q)
			adpm_pkg::BK_IDLE: pop    = head_valid;
			adpm_pkg::BK_OUT:  out_ld = !out_v_q || !out_stall;
			default: begin
				pop    = 1'b0;
				out_ld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= adpm_pkg::BK_IDLE;
			avg_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == adpm_pkg::BK_ADD) begin
				avg_q <= avg_new;
			end
			if (out_ld) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			adpm_pkg::BK_IDLE: begin
				rpt_q <= head_data[AW];
				d_q   <= $signed({1'b0, head_p}) - $signed({1'b0, avg_q});
				a_q   <= a_d;
			end
			adpm_pkg::BK_MUL: begin
				prod_q <= d_q * $signed({1'b0, a_q});
			end
			adpm_pkg::BK_ADD: begin
				norm_q <= {avg_new, {(NW-AW){1'b0}}};
				zero_q <= (avg_new == '0);
				sh_q   <= '0;
				stp_q  <= STW'(SHW-1);
			end
			adpm_pkg::BK_NORM: begin
				if ((norm_q & top_mask) == '0) begin
					norm_q <= norm_q << amt;
					sh_q   <= sh_q + amt;
				end
				stp_q <= stp_q - STW'(1);
			end
			adpm_pkg::BK_LUT: begin
				// log2 in Q8.8: (e - PF)*256 + tab[m], where e - PF = -shift
				lg_q <= LW'(adpm_pkg::LOG_TAB[mant]) - (LW'(sh_q) << 8);
			end
			adpm_pkg::BK_SCALE: begin
				scl_q <= lg_q * DB_K;
			end
			adpm_pkg::BK_OUT: begin
				if (out_ld) begin
					level_q <= zero_q ? cfg.floor_db : db_sat;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_v_q;
	assign level_db  = level_q;

endmodule

FILE: rtl/attack_decay_power_meter.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_stall   | sample, report
// out     | output    | out_valid / out_stall | level_db
// cfg     | input     | cfg_we (no wait)      | cfg_idx, cfg_data
//
// Front squares one sample per cycle, while in_stall is low, into a two-entry queue.
// Back engine per item: pop, alpha*diff multiply, accumulate; an item with report set
// adds $clog2(2*SAMPLE_BITS-1) leading-one search steps, table read, dB scale and
// output load. The back pops the next item only after it has finished the last one.
// arst_n clears control, the average and the registers to their defaults.
// out_stall holds the result; the back waits in its output step, in_stall follows.
module attack_decay_power_meter #(
	parameter int SAMPLE_BITS     = 16,
	parameter int ALPHA_FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	input  logic                                report,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [adpm_pkg::LEVEL_W-1:0] level_db,
	input  logic                                cfg_we,
	input  logic [adpm_pkg::IDX_W-1:0]          cfg_idx,
	input  logic [adpm_pkg::CFG_W-1:0]          cfg_data
);

	localparam int QW = 2*SAMPLE_BITS;

	adpm_pkg::cfg_t  cfg_q;
	logic            push;
	logic [QW-1:0]   push_data;
	logic            full;
	logic            pop;
	logic            head_valid;
	logic [QW-1:0]   head_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_alpha <= adpm_pkg::ATTACK_RESET;
			cfg_q.decay_alpha  <= adpm_pkg::DECAY_RESET;
			cfg_q.floor_db     <= adpm_pkg::FLOOR_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				adpm_pkg::REG_ATTACK: cfg_q.attack_alpha <= cfg_data;
				adpm_pkg::REG_DECAY:  cfg_q.decay_alpha  <= cfg_data;
				adpm_pkg::REG_FLOOR:  cfg_q.floor_db     <= cfg_data[adpm_pkg::LEVEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	adpm_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sample   (sample),
		.report   (report),
		.push     (push),
		.push_data(push_data),
		.full     (full)
	);

	adpm_fifo #(
		.WIDTH(QW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_data (head_data)
	);

	adpm_back #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head_valid(head_valid),
		.head_data (head_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.level_db  (level_db)
	);

endmodule

FILE: rtl/adpm_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module adpm_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [adpm_pkg::LEVEL_W-1:0] level_db
);

	`ADPM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(level_db), "level changed while stalled")
	`ADPM_ASSERT(a_out_drop, $fell(out_valid) |-> $past(!out_stall), "result dropped before taken")
	`ADPM_ASSERT_ALWAYS(a_rst_idle, !arst_n |-> !out_valid && !in_stall, "handshake active in reset")
	// the front only backs up while it holds an item taken earlier
	`ADPM_ASSERT(a_stall_src, in_stall |-> $past(in_valid && !in_stall) || $past(in_stall), "stall with no item held")

endmodule

bind attack_decay_power_meter adpm_chk u_chk (.*);

FILE: dv/attack_decay_power_meter_checker.sv
`timescale 1ns / 1ps
module attack_decay_power_meter_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic signed [15:0]                  sample,
	input  logic                                report,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [adpm_pkg::LEVEL_W-1:0] level_db,
	input  logic                                cfg_we,
	input  logic [adpm_pkg::IDX_W-1:0]          cfg_idx,
	input  logic [adpm_pkg::CFG_W-1:0]          cfg_data,
	output int                                  errors,
	output int                                  pending
);

	localparam int  POWER_FRAC = 30;
	localparam int  COEF_SHIFT = 16;
	localparam longint COEF_ONE = 64'sd1 << COEF_SHIFT;

	logic [8:0]                            log2_frac [256];
	logic [adpm_pkg::CFG_W-1:0]            rise_coef;
	logic [adpm_pkg::CFG_W-1:0]            fall_coef;
	logic signed [adpm_pkg::LEVEL_W-1:0]   floor_level;
	logic [30:0]                           avg_power;
	logic [30:0]                           new_avg;
	logic signed [adpm_pkg::LEVEL_W-1:0]   got_level;
	logic signed [adpm_pkg::LEVEL_W-1:0]   levels_due [$];
	int                                    err_count = 0;

	// fraction of log2(1+idx/256) in Q.8: square repeatedly, one bit per squaring
	function automatic logic [8:0] log2_mantissa(int unsigned idx);
		logic [63:0] acc;
		logic [9:0]  bits;
		acc = 64'(256 + idx) << 22;
		bits = '0;
		repeat (9) begin
			acc = (acc * acc) >> POWER_FRAC;
			bits = bits << 1;
			if (acc[31]) begin
				bits[0] = 1'b1;
				acc = acc >> 1;
			end
		end
		return 9'((bits + 10'd1) >> 1);
	endfunction

	function automatic logic [30:0] average_after(logic [30:0] avg, logic signed [15:0] s,
			logic [adpm_pkg::CFG_W-1:0] rise, logic [adpm_pkg::CFG_W-1:0] fall);
		longint pw;
		longint diff;
		longint coef;
		pw = longint'(s) * longint'(s);
		coef = (pw > longint'(avg)) ? longint'(rise) : longint'(fall);
		if (coef > COEF_ONE)
			coef = COEF_ONE;
		diff = pw - longint'(avg);
		return 31'(longint'(avg) + ((coef * diff) >>> COEF_SHIFT));
	endfunction

	function automatic logic signed [adpm_pkg::LEVEL_W-1:0] db_level(logic [30:0] avg,
			logic signed [adpm_pkg::LEVEL_W-1:0] fl);
		int         msb;
		int         b;
		logic [7:0] mant;
		longint     l2;
		longint     db;
		if (avg == '0)
			return fl;
		msb = 0;
		for (b = 0; b < 31; b++)
			if (avg[b])
				msb = b;
		if (msb >= 8)
			mant = 8'(avg >> (msb - 8));
		else
			mant = 8'(avg << (8 - msb));
		l2 = longint'(msb - POWER_FRAC) * 256 + longint'(log2_frac[mant]);
		db = (l2 * adpm_pkg::DB_PER_OCT_Q8) >>> 8;
		if (db < -32768)
			db = -32768;
		if (db > 32767)
			db = 32767;
		return adpm_pkg::LEVEL_W'(db);
	endfunction

	initial begin
		for (int i = 0; i < 256; i++)
			log2_frac[i] = log2_mantissa(i);
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_coef <= adpm_pkg::ATTACK_RESET;
			fall_coef <= adpm_pkg::DECAY_RESET;
			floor_level <= adpm_pkg::FLOOR_RESET;
			avg_power <= '0;
			levels_due.delete();
			pending <= 0;
			errors <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					adpm_pkg::REG_ATTACK: rise_coef <= cfg_data;
					adpm_pkg::REG_DECAY:  fall_coef <= cfg_data;
					adpm_pkg::REG_FLOOR:  floor_level <= cfg_data[adpm_pkg::LEVEL_W-1:0];
					default: ;
				endcase
			end
			// pop before push: a result cannot belong to an item taken at the same edge
			if (out_valid && !out_stall) begin
				got_level = level_db;
				if (levels_due.size() == 0) begin
					if (err_count < 10)
						$display("unexpected level_db item: got %0d", got_level);
					err_count++;
				end else begin
					if (got_level !== levels_due[0]) begin
						if (err_count < 10)
							$display("level_db mismatch: expected %0d, got %0d",
								levels_due[0], got_level);
						err_count++;
					end
					void'(levels_due.pop_front());
				end
			end
			if (in_valid && !in_stall) begin
				new_avg = average_after(avg_power, sample, rise_coef, fall_coef);
				avg_power <= new_avg;
				if (report)
					levels_due.insert(levels_due.size(), db_level(new_avg, floor_level));
			end
			pending <= levels_due.size();
			errors <= err_count;
		end
	end

endmodule

FILE: dv/attack_decay_power_meter_test.sv
`timescale 1ns / 1ps
module attack_decay_power_meter_test;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 40;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b1;
	logic                                in_valid = 1'b0;
	logic                                in_stall;
	logic signed [15:0]                  sample = '0;
	logic                                report = 1'b0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic signed [adpm_pkg::LEVEL_W-1:0] level_db;
	logic                                cfg_we = 1'b0;
	logic [adpm_pkg::IDX_W-1:0]          cfg_idx = '0;
	logic [adpm_pkg::CFG_W-1:0]          cfg_data = '0;
	logic                                calm = 1'b0;
	int                                  errors;
	int                                  pending;
	int                                  cycles = 0;

	attack_decay_power_meter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sample   (sample),
		.report   (report),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.level_db (level_db),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	attack_decay_power_meter_checker i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sample   (sample),
		.report   (report),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.level_db (level_db),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 10);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_sample(input logic signed [15:0] s, input logic r);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < 10)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		report <= r;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// block must be idle before a register write; items without report give no result
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_settings(input logic [adpm_pkg::CFG_W-1:0] rise,
			input logic [adpm_pkg::CFG_W-1:0] fall,
			input logic signed [adpm_pkg::LEVEL_W-1:0] fl);
		cfg_we <= 1'b1;
		cfg_idx <= adpm_pkg::REG_ATTACK;
		cfg_data <= rise;
		@(posedge clk);
		cfg_idx <= adpm_pkg::REG_DECAY;
		cfg_data <= fall;
		@(posedge clk);
		cfg_idx <= adpm_pkg::REG_FLOOR;
		cfg_data <= {1'b0, fl};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [15:0] random_sample();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 16'($urandom);
			4, 5:       return 16'($urandom_range(0, 32)) - 16'sd16;
			6:          return '0;
			7:          return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			default:    return 16'($urandom_range(0, 2048)) - 16'sd1024;
		endcase
	endfunction

	initial begin
		// falling edge once every process waits on it
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: zero average, full scale both signs, tiny powers
		send_sample(16'sd0, 1'b1);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd0, 1'b1);
		send_sample(16'sd1, 1'b1);
		send_sample(-16'sd1, 1'b1);
		send_sample(16'sh5555, 1'b0);
		send_sample(16'sh2AAA, 1'b1);
		drain();

		// unity coefficient: average jumps to the power
		write_settings(17'd65536, 17'd65536, 16'sd0);
		send_sample(16'sd0, 1'b1);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sd1, 1'b1);
		send_sample(-16'sd3, 1'b1);
		drain();

		// coefficients above one saturate
		write_settings(17'h1FFFF, 17'h1FFFF, -16'sd32768);
		send_sample(16'sd255, 1'b1);
		send_sample(16'sd0, 1'b1);
		send_sample(-16'sd32767, 1'b1);
		drain();

		// zero coefficients freeze the average
		write_settings(17'd0, 17'd0, -16'sd1);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(-16'sd12345, 1'b1);
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: write_settings(adpm_pkg::ATTACK_RESET, adpm_pkg::DECAY_RESET,
					adpm_pkg::FLOOR_RESET);
				1: write_settings(17'd65536, 17'd1, -16'sd32768);
				2: write_settings(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
					16'(-$urandom_range(0, 32768)));
				3: write_settings(17'd1, 17'd65536, 16'sd0);
				default: write_settings(17'h1FFFF, 17'($urandom_range(0, 2000)),
					16'(-$urandom_range(0, 32768)));
			endcase
			calm <= (phase == 2);
			for (int n = 0; n < 100; n++)
				send_sample(random_sample(), $urandom_range(0, 3) == 0);
			drain();
			calm <= 1'b0;
		end

		if (errors == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
